// File: rtl/wma_pkg.sv
// Package: types, widths and codes shared by the weighted moment accumulator.
package wma_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_MERGE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_ZERO_WGHT = 1'b1;

    localparam int IN_BITS  = 2 + 32 + 32 + 32 + 48 + 64 + 32 + 64;
    localparam int IN_BYTES = (IN_BITS + 7) / 8;
    localparam int OUT_BITS  = 32 + 32 + 48 + 48 + 32 + 1;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_A_MUL1,
        ST_A_MUL1W,
        ST_A_DIV1,
        ST_A_DIV1W,
        ST_A_MEAN,
        ST_A_MUL2,
        ST_A_MUL2W,
        ST_A_MUL3,
        ST_A_MUL3W,
        ST_A_COMMIT,
        ST_M_MUL1,
        ST_M_MUL1W,
        ST_M_DIV1,
        ST_M_DIV1W,
        ST_M_MUL2,
        ST_M_MUL2W,
        ST_M_MUL3,
        ST_M_MUL3W,
        ST_M_MUL4,
        ST_M_MUL4W,
        ST_M_DIV2,
        ST_M_DIV2W,
        ST_M_COMMIT,
        ST_R_DIV1,
        ST_R_DIV1W,
        ST_R_MUL,
        ST_R_MULW,
        ST_R_DIV2,
        ST_R_DIV2W,
        ST_OUT
    } state_t;

endpackage

// File: rtl/weighted_moment_accumulator.sv
// Top level: weighted Welford mean and variance accumulator on a shared unit.
// Each 128-step rounded division and each 64x64 multiply, summed from 32x32
// partial products, runs on the shared unit, one operation at a time.
// Items are taken one at a time: s_tready is high only while idle, so the
// next item is not taken until the last result has been accepted.
// Reset: aresetn (synchronous, active low) clears all totals, mean and sums.
module weighted_moment_accumulator
    import wma_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // action, sample_value, sample_weight, other_count, other_weight,
    // other_weight_sq, other_mean, other_centered_sum (low bit up)
    input  logic [IN_BYTES*8-1:0]    s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // mean_out, variance_out, effective_count_out, total_weight_out,
    // count_out, status (low bit up)
    output logic [OUT_BYTES*8-1:0]   m_tdata
);

    localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;
    localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

    state_t state_reg, state_next;

    logic [31:0]        count_reg;
    logic [47:0]        tw_reg;
    logic [63:0]        wsq_reg;
    logic signed [63:0] mean_reg;
    logic [63:0]        cs_reg;

    logic [1:0]         act_reg;
    logic signed [63:0] v_reg;
    logic [31:0]        w_reg;
    logic [31:0]        ocnt_reg;
    logic [47:0]        ow_reg;
    logic [63:0]        owsq_reg;
    logic signed [63:0] om_reg;
    logic [63:0]        ocs_reg;
    logic               status_reg;

    logic [47:0]        nw_reg;
    logic signed [63:0] delta_reg;
    logic [63:0]        h_reg;
    logic [127:0]       prod_reg;
    logic               prod_sat_reg;
    logic [63:0]        var_reg;
    logic [63:0]        eff_reg;

    // shared unit: multiply (4 partial products of 32x32) or 128/64 divide
    logic         mul_go, div_go, unit_busy_reg, unit_div_reg;
    logic [63:0]  op_a, op_d;
    logic [127:0] op_n;
    logic [63:0]  ua_reg, ub_reg;
    logic [127:0] un_reg, uq_reg, acc_reg;
    logic [63:0]  ur_reg;
    logic [7:0]   ucnt_reg;
    logic         unit_done;

    assign unit_done = unit_busy_reg && ((unit_div_reg && ucnt_reg == 8'd129)
                       || (!unit_div_reg && ucnt_reg == 8'd4));

    logic [64:0]  r_shift;
    logic         r_ge;
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [6:0]   pp_shift;
    assign r_shift = {ur_reg, un_reg[127]};
    assign r_ge = r_shift >= {1'b0, ub_reg};
    assign pa = ucnt_reg[0] ? ua_reg[63:32] : ua_reg[31:0];
    assign pb = ucnt_reg[1] ? ub_reg[63:32] : ub_reg[31:0];
    assign pp = {32'd0, pa} * {32'd0, pb};
    assign pp_shift = {ucnt_reg[0] & ucnt_reg[1], ucnt_reg[0] ^ ucnt_reg[1], 5'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_busy_reg <= 1'b0;
            unit_div_reg  <= 1'b0;
            ucnt_reg      <= '0;
        end else if (mul_go) begin
            unit_busy_reg <= 1'b1;
            unit_div_reg  <= 1'b0;
            ucnt_reg      <= '0;
            ua_reg        <= op_a;
            ub_reg        <= op_d;
            acc_reg       <= '0;
        end else if (div_go) begin
            unit_busy_reg <= 1'b1;
            unit_div_reg  <= 1'b1;
            ucnt_reg      <= '0;
            un_reg        <= op_n;
            ub_reg        <= op_d;
            ur_reg        <= '0;
            uq_reg        <= '0;
        end else if (unit_done) begin
            unit_busy_reg <= 1'b0;
        end else if (unit_busy_reg) begin
            ucnt_reg <= ucnt_reg + 8'd1;
            if (unit_div_reg) begin
                if (ucnt_reg == 8'd128) begin
                    if ({1'b0, ur_reg} >= {1'b0, ub_reg} - {1'b0, ur_reg}) begin
                        uq_reg <= uq_reg + 128'd1;
                    end
                end else begin
                    un_reg <= {un_reg[126:0], 1'b0};
                    if (r_ge) begin
                        ur_reg <= 64'(r_shift - {1'b0, ub_reg});
                        uq_reg <= {uq_reg[126:0], 1'b1};
                    end else begin
                        ur_reg <= r_shift[63:0];
                        uq_reg <= {uq_reg[126:0], 1'b0};
                    end
                end
            end else begin
                acc_reg <= acc_reg + ({64'd0, pp} << pp_shift);
            end
        end
    end

    // helpers
    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        mag64 = x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic signed [63:0] clampv(input logic signed [63:0] x);
        if (x > VMAX) clampv = VMAX;
        else if (x < VMIN) clampv = VMIN;
        else clampv = x;
    endfunction

    function automatic logic [63:0] add64s(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        add64s = s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] drop_frac(input logic [127:0] x, input logic sat);
        logic [128:0] s;
        s = {1'b0, x} + (129'd1 << (FRAC_BITS - 1));
        if (sat || s[128] || (s[127:0] >> FRAC_BITS) > 128'({64{1'b1}})) drop_frac = '1;
        else drop_frac = 64'(s[127:0] >> FRAC_BITS);
    endfunction

    logic [127:0] nxt_prod;
    logic         nxt_sat;

    logic signed [63:0] new_mean;
    logic [64:0]        nw_sum;
    logic [47:0]        nw_sat;
    logic signed [63:0] step_s;
    assign nw_sum = {17'd0, tw_reg} + {33'd0, w_reg};
    assign nw_sat = nw_sum > {1'b0, MAX48} ? 48'hFFFF_FFFF_FFFF : nw_sum[47:0];
    assign step_s = delta_reg[63] ? -$signed(uq_reg[63:0]) : $signed(uq_reg[63:0]);
    assign new_mean = clampv(mean_reg + step_s);

    logic [64:0] mt_sum;
    logic [47:0] mt_sat;
    assign mt_sum = {17'd0, tw_reg} + {17'd0, ow_reg};
    assign mt_sat = mt_sum > {1'b0, MAX48} ? 48'hFFFF_FFFF_FFFF : mt_sum[47:0];

    // three-factor product: prod_reg (<=128b) times a 64-bit factor, via
    // two multiplies: low word first, high word second
    logic [127:0] lo_part_reg;

    // merge path reuses ST_A_DIV1 for the mean step; flag it
    logic merge_reg;

    always_comb begin
        state_next = state_reg;
        mul_go = 1'b0;
        div_go = 1'b0;
        op_a = '0;
        op_d = 64'd1;
        op_n = '0;
        case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_DECODE;
            ST_DECODE: begin
                if (act_reg == ACT_ADD && w_reg != 32'd0) state_next = ST_A_MUL1;
                else if (act_reg == ACT_MERGE && ow_reg != 48'd0 && tw_reg != 48'd0)
                    state_next = ST_M_MUL1;
                else state_next = ST_R_DIV1;
            end
            ST_A_MUL1: begin
                mul_go = 1'b1; op_a = {32'd0, w_reg}; op_d = mag64(delta_reg);
                state_next = ST_A_MUL1W;
            end
            ST_A_MUL1W: if (unit_done) state_next = ST_A_DIV1;
            ST_A_DIV1: begin
                div_go = 1'b1; op_n = prod_reg; op_d = {16'd0, nw_reg};
                state_next = ST_A_DIV1W;
            end
            ST_A_DIV1W: if (unit_done) state_next = ST_A_MEAN;
            ST_A_MEAN:  state_next = merge_reg ? ST_R_DIV1 : ST_A_MUL2;
            ST_A_MUL2: begin
                mul_go = 1'b1; op_a = prod_reg[63:0]; op_d = mag64(v_reg - mean_reg);
                state_next = ST_A_MUL2W;
            end
            ST_A_MUL2W: if (unit_done) state_next = ST_A_MUL3;
            ST_A_MUL3: begin
                mul_go = 1'b1; op_a = prod_reg[127:64]; op_d = mag64(v_reg - mean_reg);
                state_next = ST_A_MUL3W;
            end
            ST_A_MUL3W: if (unit_done) state_next = ST_A_COMMIT;
            ST_A_COMMIT: state_next = ST_R_DIV1;
            ST_M_MUL1: begin
                mul_go = 1'b1; op_a = {16'd0, tw_reg}; op_d = {16'd0, ow_reg};
                state_next = ST_M_MUL1W;
            end
            ST_M_MUL1W: if (unit_done) state_next = ST_M_DIV1;
            ST_M_DIV1: begin
                div_go = 1'b1; op_n = prod_reg; op_d = {16'd0, nw_reg};
                state_next = ST_M_DIV1W;
            end
            ST_M_DIV1W: if (unit_done) state_next = ST_M_MUL2;
            ST_M_MUL2: begin
                mul_go = 1'b1; op_a = h_reg; op_d = mag64(delta_reg);
                state_next = ST_M_MUL2W;
            end
            ST_M_MUL2W: if (unit_done) state_next = ST_M_MUL3;
            ST_M_MUL3: begin
                mul_go = 1'b1; op_a = prod_reg[63:0]; op_d = mag64(delta_reg);
                state_next = ST_M_MUL3W;
            end
            ST_M_MUL3W: if (unit_done) state_next = ST_M_MUL4;
            ST_M_MUL4: begin
                mul_go = 1'b1; op_a = prod_reg[127:64]; op_d = mag64(delta_reg);
                state_next = ST_M_MUL4W;
            end
            ST_M_MUL4W: if (unit_done) state_next = ST_M_DIV2;
            ST_M_DIV2: begin
                mul_go = 1'b1; op_a = {16'd0, ow_reg}; op_d = mag64(delta_reg);
                state_next = ST_M_DIV2W;
            end
            ST_M_DIV2W: if (unit_done) state_next = ST_M_COMMIT;
            ST_M_COMMIT: state_next = ST_A_DIV1;
            ST_R_DIV1: begin
                if (tw_reg != 48'd0) begin
                    div_go = 1'b1; op_n = {64'd0, cs_reg}; op_d = {16'd0, tw_reg};
                end
                state_next = ST_R_DIV1W;
            end
            ST_R_DIV1W: if (tw_reg == 48'd0 || unit_done) state_next = ST_R_MUL;
            ST_R_MUL: begin
                mul_go = 1'b1; op_a = {16'd0, tw_reg}; op_d = {16'd0, tw_reg};
                state_next = ST_R_MULW;
            end
            ST_R_MULW: if (unit_done) state_next = ST_R_DIV2;
            ST_R_DIV2: begin
                if (wsq_reg != 64'd0) begin
                    div_go = 1'b1; op_n = prod_reg << FRAC_BITS; op_d = wsq_reg;
                end
                state_next = ST_R_DIV2W;
            end
            ST_R_DIV2W: if (wsq_reg == 64'd0 || unit_done) state_next = ST_OUT;
            ST_OUT: if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        nxt_prod = acc_reg;
        nxt_sat  = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            tw_reg    <= '0;
            wsq_reg   <= '0;
            mean_reg  <= '0;
            cs_reg    <= '0;
            merge_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    act_reg  <= s_tdata[1:0];
                    v_reg    <= clampv(64'($signed(s_tdata[33:2])));
                    w_reg    <= s_tdata[65:34];
                    ocnt_reg <= s_tdata[97:66];
                    ow_reg   <= s_tdata[145:98];
                    owsq_reg <= s_tdata[209:146];
                    om_reg   <= clampv(64'($signed(s_tdata[241:210])));
                    ocs_reg  <= s_tdata[305:242];
                    merge_reg <= 1'b0;
                end
                ST_DECODE: begin
                    status_reg <= STATUS_OK;
                    var_reg <= '0;
                    eff_reg <= '0;
                    if (act_reg == ACT_ADD) begin
                        if (w_reg == 32'd0) status_reg <= STATUS_ZERO_WGHT;
                        nw_reg    <= nw_sat;
                        delta_reg <= v_reg - mean_reg;
                    end else if (act_reg == ACT_MERGE) begin
                        nw_reg    <= mt_sat;
                        delta_reg <= om_reg - mean_reg;
                        if (ow_reg != 48'd0 && tw_reg == 48'd0) begin
                            count_reg <= ocnt_reg;
                            tw_reg    <= ow_reg;
                            wsq_reg   <= owsq_reg;
                            mean_reg  <= om_reg;
                            cs_reg    <= ocs_reg;
                        end
                    end else if (act_reg == ACT_CLEAR) begin
                        count_reg <= '0;
                        tw_reg    <= '0;
                        wsq_reg   <= '0;
                        mean_reg  <= '0;
                        cs_reg    <= '0;
                    end
                end
                ST_A_MUL1W, ST_M_MUL1W, ST_M_MUL2W, ST_R_MULW:
                    if (unit_done) begin
                        prod_reg <= nxt_prod;
                        prod_sat_reg <= nxt_sat;
                    end
                ST_A_DIV1W: if (unit_done) mean_reg <= mean_reg;
                ST_A_MEAN: begin
                    mean_reg <= new_mean;
                    if (merge_reg) tw_reg <= nw_reg;
                end
                ST_A_MUL2W: if (unit_done) lo_part_reg <= acc_reg;
                ST_A_MUL3W, ST_M_MUL4W: if (unit_done) begin
                    prod_sat_reg <= acc_reg[127:64] != 64'd0
                        || ({1'b0, acc_reg[63:0]} + {1'b0, lo_part_reg[127:64]}) > {1'b0, {64{1'b1}}};
                    prod_reg <= {acc_reg[63:0] + lo_part_reg[127:64], lo_part_reg[63:0]};
                end
                ST_M_MUL3W: if (unit_done) lo_part_reg <= acc_reg;
                ST_A_COMMIT: begin
                    cs_reg    <= add64s(cs_reg, drop_frac(prod_reg, prod_sat_reg));
                    tw_reg    <= nw_reg;
                    wsq_reg   <= add64s(wsq_reg, {32'd0, w_reg} * {32'd0, w_reg});
                    count_reg <= count_reg == 32'hFFFF_FFFF ? count_reg : count_reg + 32'd1;
                end
                ST_M_DIV1W: if (unit_done) h_reg <= uq_reg[63:0];
                ST_M_DIV2W: if (unit_done) prod_reg <= acc_reg;
                ST_M_COMMIT: begin
                    cs_reg <= add64s(add64s(cs_reg, ocs_reg),
                                     drop_frac(lo_part_reg, prod_sat_reg));
                    wsq_reg <= add64s(wsq_reg, owsq_reg);
                    count_reg <= (33'(count_reg) + 33'(ocnt_reg)) > 33'h0_FFFF_FFFF
                        ? 32'hFFFF_FFFF : count_reg + ocnt_reg;
                    merge_reg <= 1'b1;
                end
                ST_R_DIV1W: if (unit_done) begin
                    var_reg <= uq_reg > 128'h0_FFFF_FFFF ? 64'hFFFF_FFFF : uq_reg[63:0];
                end
                ST_R_DIV2W: if (unit_done) begin
                    eff_reg <= uq_reg > {64'd0, MAX48} ? MAX48 : uq_reg[63:0];
                end
                default: ;
            endcase
            // merge's pairwise term is held in lo_part_reg before the mean step
            if (state_reg == ST_M_MUL4W && unit_done) begin
                lo_part_reg <= {acc_reg[63:0] + lo_part_reg[127:64], lo_part_reg[63:0]};
            end
        end
    end

    logic signed [63:0] m_sat;
    assign m_sat = mean_reg > 64'sd2147483647 ? 64'sd2147483647 :
                   mean_reg < -64'sd2147483648 ? -64'sd2147483648 : mean_reg;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_OUT;
    assign m_tdata = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, status_reg, count_reg, tw_reg,
                      eff_reg[47:0], var_reg[31:0], m_sat[31:0]};

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_unit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_go && div_go)) else $error("unit double start");
    a_tw_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (tw_reg != 48'd0 || var_reg == 64'd0))
        else $error("variance without weight");

endmodule

// File: bench/tb_weighted_moment_accumulator.sv
// Testbench for the weighted moment accumulator: stream driver, predictor and scoreboard.
`timescale 1ns / 1ps

module tb_weighted_moment_accumulator
    import wma_pkg::*;
();

    typedef struct packed {
        logic [63:0] other_centered_sum;
        logic [31:0] other_mean;
        logic [63:0] other_weight_sq;
        logic [47:0] other_weight;
        logic [31:0] other_count;
        logic [31:0] sample_weight;
        logic [31:0] sample_value;
        logic [1:0]  action;
    } stat_item_t;

    typedef struct packed {
        logic        status;
        logic [31:0] count_out;
        logic [47:0] total_weight_out;
        logic [47:0] effective_count_out;
        logic [31:0] variance_out;
        logic [31:0] mean_out;
    } moment_report_t;

    localparam logic [63:0]  MAX64 = '1;
    localparam logic [47:0]  MAX48 = '1;
    localparam logic [127:0] MAX128 = '1;

    class moment_scoreboard;
        logic [31:0] n_samples;
        logic [47:0] weight_total;
        logic [63:0] weight_sq_total;
        longint      mean_acc;
        logic [63:0] spread_sum;
        moment_report_t expected_reports[$];
        int unsigned failures;

        function new();
            n_samples = 0;
            weight_total = 0;
            weight_sq_total = 0;
            mean_acc = 0;
            spread_sum = 0;
            failures = 0;
        endfunction

        function logic [127:0] sat_mul(logic [127:0] x, logic [63:0] b);
            logic [191:0] p;
            p = {64'd0, x} * {128'd0, b};
            return (p[191:128] != 0) ? MAX128 : p[127:0];
        endfunction

        function logic [63:0] round_drop_frac(logic [127:0] x);
            logic [128:0] s;
            s = {1'b0, x} + (129'd1 << (FRAC_BITS - 1));
            if (s[128]) return MAX64;
            s = s >> FRAC_BITS;
            return (s[128:64] != 0) ? MAX64 : s[63:0];
        endfunction

        function logic [127:0] rounded_quot(logic [127:0] n, logic [63:0] d);
            logic [127:0] q, r;
            q = n / {64'd0, d};
            r = n % {64'd0, d};
            if (r >= {64'd0, d} - r) q = q + 128'd1;
            return q;
        endfunction

        function logic [63:0] magnitude(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        function longint mean_step(logic [63:0] a, longint delta, logic [63:0] d);
            logic [63:0] q;
            q = 64'(rounded_quot({64'd0, a} * {64'd0, magnitude(delta)}, d));
            return delta < 0 ? -longint'(q) : longint'(q);
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? MAX64 : s[63:0];
        endfunction

        function logic [47:0] sat_add48(logic [47:0] a, logic [47:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[48] ? MAX48 : s[47:0];
        endfunction

        function logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void note_input(stat_item_t it);
            moment_report_t rep;
            logic [63:0] w, ob, h, q, rm;
            logic [47:0] nw;
            logic [127:0] n, eq;
            longint v, om, delta;
            rep.status = STATUS_OK;
            if (it.action == ACT_ADD) begin
                w = {32'd0, it.sample_weight};
                if (w == 0) begin
                    rep.status = STATUS_ZERO_WGHT;
                end else begin
                    v = clamp32(longint'($signed(it.sample_value)));
                    nw = sat_add48(weight_total, w[47:0]);
                    delta = v - mean_acc;
                    mean_acc = clamp32(mean_acc + mean_step(w, delta, {16'd0, nw}));
                    n = sat_mul({64'd0, w} * {64'd0, magnitude(delta)},
                                magnitude(v - mean_acc));
                    spread_sum = sat_add64(spread_sum, round_drop_frac(n));
                    weight_total = nw;
                    weight_sq_total = sat_add64(weight_sq_total, w * w);
                    n_samples = sat_add32(n_samples, 32'd1);
                end
            end else if (it.action == ACT_MERGE) begin
                ob = {16'd0, it.other_weight};
                om = clamp32(longint'($signed(it.other_mean)));
                if (ob == 0) begin
                end else if (weight_total == 0) begin
                    n_samples = it.other_count;
                    weight_total = it.other_weight;
                    weight_sq_total = it.other_weight_sq;
                    mean_acc = om;
                    spread_sum = it.other_centered_sum;
                end else begin
                    nw = sat_add48(weight_total, it.other_weight);
                    delta = om - mean_acc;
                    h = 64'(rounded_quot({80'd0, weight_total} * {64'd0, ob}, {16'd0, nw}));
                    n = sat_mul({64'd0, h} * {64'd0, magnitude(delta)}, magnitude(delta));
                    mean_acc = clamp32(mean_acc + mean_step(ob, delta, {16'd0, nw}));
                    spread_sum = sat_add64(sat_add64(spread_sum, it.other_centered_sum),
                                           round_drop_frac(n));
                    weight_total = nw;
                    weight_sq_total = sat_add64(weight_sq_total, it.other_weight_sq);
                    n_samples = sat_add32(n_samples, it.other_count);
                end
            end else if (it.action == ACT_CLEAR) begin
                n_samples = 0;
                weight_total = 0;
                weight_sq_total = 0;
                mean_acc = 0;
                spread_sum = 0;
            end
            rep.mean_out = 32'(clamp32(mean_acc));
            rep.variance_out = 0;
            if (weight_total != 0) begin
                q = spread_sum / {16'd0, weight_total};
                rm = spread_sum % {16'd0, weight_total};
                if (rm >= {16'd0, weight_total} - rm) q = q + 64'd1;
                rep.variance_out = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            end
            rep.effective_count_out = 0;
            if (weight_sq_total != 0) begin
                n = ({80'd0, weight_total} * {80'd0, weight_total}) << FRAC_BITS;
                eq = rounded_quot(n, weight_sq_total);
                rep.effective_count_out = (eq > {80'd0, MAX48}) ? MAX48 : eq[47:0];
            end
            rep.total_weight_out = weight_total;
            rep.count_out = n_samples;
            expected_reports.push_back(rep);
        endfunction

        function void check_result(moment_report_t got);
            moment_report_t exp_rep;
            if (expected_reports.size() == 0) begin
                $error("unexpected result item %h", got);
                failures++;
                return;
            end
            exp_rep = expected_reports.pop_front();
            if (got.mean_out !== exp_rep.mean_out) begin
                $error("mean_out exp %h got %h", exp_rep.mean_out, got.mean_out);
                failures++;
            end
            if (got.variance_out !== exp_rep.variance_out) begin
                $error("variance_out exp %h got %h", exp_rep.variance_out, got.variance_out);
                failures++;
            end
            if (got.effective_count_out !== exp_rep.effective_count_out) begin
                $error("effective_count_out exp %h got %h",
                       exp_rep.effective_count_out, got.effective_count_out);
                failures++;
            end
            if (got.total_weight_out !== exp_rep.total_weight_out) begin
                $error("total_weight_out exp %h got %h",
                       exp_rep.total_weight_out, got.total_weight_out);
                failures++;
            end
            if (got.count_out !== exp_rep.count_out) begin
                $error("count_out exp %h got %h", exp_rep.count_out, got.count_out);
                failures++;
            end
            if (got.status !== exp_rep.status) begin
                $error("status exp %h got %h", exp_rep.status, got.status);
                failures++;
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_BYTES*8-1:0]   s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_BYTES*8-1:0]  m_tdata;

    moment_scoreboard sb;

    weighted_moment_accumulator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_item(stat_item_t it);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_BYTES*8-IN_BITS){1'b0}}, it};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(it);
    endtask

    function automatic stat_item_t make_item(logic [1:0] act);
        stat_item_t it;
        it = '0;
        it.action = act;
        it.sample_value = ($urandom_range(0, 4) == 0) ? $urandom
                        : 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
        case ($urandom_range(0, 9))
            0: it.sample_weight = 32'd0;
            1: it.sample_weight = $urandom;
            default: it.sample_weight = $urandom_range(1, 32'h0004_0000);
        endcase
        it.other_mean = ($urandom_range(0, 4) == 0) ? $urandom
                      : 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
        if ($urandom_range(0, 5) == 0) begin
            it.other_count = $urandom;
            it.other_weight = 48'({$urandom, $urandom});
            it.other_weight_sq = {$urandom, $urandom};
            it.other_centered_sum = {$urandom, $urandom};
        end else begin
            it.other_count = $urandom_range(0, 200);
            it.other_weight = ($urandom_range(0, 9) == 0) ? 48'd0
                            : 48'($urandom_range(1, 32'h0100_0000));
            it.other_weight_sq = {$urandom_range(0, 255), $urandom};
            it.other_centered_sum = {$urandom_range(0, 4095), $urandom};
        end
        return it;
    endfunction

    initial begin
        moment_report_t got;
        int gap;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = m_tdata[OUT_BITS-1:0];
            sb.check_result(got);
        end
    end

    initial begin
        stat_item_t it;
        int pick;
        sb = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        it = '0; it.action = ACT_ADD; it.sample_weight = 32'd0; send_item(it);
        it.sample_value = 32'h7FFF_FFFF; it.sample_weight = 32'h0001_0000; send_item(it);
        it.sample_value = 32'h8000_0000; it.sample_weight = 32'hFFFF_FFFF; send_item(it);
        it.sample_value = 32'h0000_0001; it.sample_weight = 32'h0000_0001; send_item(it);
        it.sample_value = 32'hFFFF_FFFF; it.sample_weight = 32'h0002_0000; send_item(it);
        it = '0; it.action = ACT_MERGE; it.other_mean = 32'h7FFF_FFFF; send_item(it);
        it.other_count = 32'hFFFF_FFFF; it.other_weight = MAX48;
        it.other_weight_sq = MAX64; it.other_centered_sum = MAX64; send_item(it);
        it = '0; it.action = ACT_ADD; it.sample_value = 32'h0010_0000;
        it.sample_weight = 32'hFFFF_FFFF; send_item(it);
        it = '0; it.action = ACT_NOP; it.sample_weight = 32'h1234_5678; send_item(it);
        it = '0; it.action = ACT_CLEAR; send_item(it);
        it = '0; it.action = ACT_MERGE; it.other_count = 32'd5;
        it.other_weight = 48'h0000_0005_0000; it.other_weight_sq = 64'h0000_0005_0000_0000;
        it.other_mean = 32'h8000_0000; it.other_centered_sum = 64'h0000_0010_0000_0000;
        send_item(it);
        it.other_mean = 32'h7FFF_FFFF; it.other_weight = 48'h0000_0003_0000; send_item(it);
        it = '0; it.action = ACT_ADD; it.sample_value = 32'h8000_0000;
        it.sample_weight = 32'h0000_8000; send_item(it);
        it.action = ACT_ADD; it.sample_weight = 32'd0; send_item(it);
        it = '0; it.action = ACT_CLEAR; send_item(it);
        it = '0; it.action = ACT_ADD; it.sample_value = 32'h0003_0000;
        it.sample_weight = 32'h0001_0000; send_item(it);
        it.sample_value = 32'h0005_0000; send_item(it);

        for (int i = 0; i < 1000; i++) begin
            if (i == 500) begin
                s_tvalid <= 1'b0;
                while (sb.expected_reports.size() != 0) @(posedge aclk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 62)      it = make_item(ACT_ADD);
            else if (pick < 88) it = make_item(ACT_MERGE);
            else if (pick < 95) it = make_item(ACT_CLEAR);
            else                it = make_item(ACT_NOP);
            send_item(it);
        end
        s_tvalid <= 1'b0;

        while (sb.expected_reports.size() != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
